>>> hw/rtl/tep_pkg.sv
package tep_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CFG_BITS       = 11;
  localparam int TEX_BITS       = 8;
  localparam int COLOR_BITS     = 6;
  localparam int FC_BITS        = 8;
  localparam int FRAME_WRAP     = 200;
  localparam int PADDR_BITS     = 3;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd240;
  localparam logic [TEX_BITS-1:0] ANGLE_HALF   = 8'd128;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // Reciprocal: 2^26 / r by long division, one quotient bit a step.
  localparam int DIV_BITS   = 27;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;
  // Square root of the 27-bit quotient, one result bit a step.
  localparam int SQ_ITERS   = 14;
  localparam int SQ_STEPS   = 4;
  localparam int SQ_STAGES  = (SQ_ITERS + SQ_STEPS - 1) / SQ_STEPS;

  localparam int COR_ITERS  = 16;
  localparam int COR_STEPS  = 4;
  localparam int COR_STAGES = COR_ITERS / COR_STEPS;
  localparam int ACC_BITS   = 18;

  localparam int LAT_RADIUS = 3;
  localparam int LAT_RSQRT  = DIV_STAGES + SQ_STAGES;
  localparam int LAT_CORDIC = COR_STAGES + 2;

  localparam logic signed [ACC_BITS-1:0] ATAN_TAB [COR_ITERS] = '{
    18'sd16384, 18'sd9672, 18'sd5110, 18'sd2594, 18'sd1302, 18'sd652, 18'sd326, 18'sd163,
    18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1, 18'sd1
  };

  typedef logic [TEX_BITS-1:0]   scroll_tab_t [256];
  typedef logic [COLOR_BITS-1:0] color_tab_t  [256];

  function automatic int diff_bits(int cb);
    return ((cb + 1 > CFG_BITS) ? cb + 1 : CFG_BITS) + 1;
  endfunction

  function automatic scroll_tab_t make_x_scroll();
    scroll_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = TEX_BITS'((i * 256) / 100);
    return t;
  endfunction

  function automatic scroll_tab_t make_y_scroll();
    scroll_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = TEX_BITS'((i * 256) / 200);
    return t;
  endfunction

  function automatic color_tab_t make_mod37();
    color_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = COLOR_BITS'(i % 37);
    return t;
  endfunction

  localparam scroll_tab_t X_SCROLL  = make_x_scroll();
  localparam scroll_tab_t Y_SCROLL  = make_y_scroll();
  localparam color_tab_t  MOD37_TAB = make_mod37();

endpackage

>>> hw/rtl/tep_radius.sv
module tep_radius #(
  parameter int COORD_BITS = tep_pkg::COORD_BITS_DEF,
  localparam int DW = tep_pkg::diff_bits(COORD_BITS)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [COORD_BITS-1:0]         pixel_x,
  input  logic [COORD_BITS-1:0]         pixel_y,
  input  logic [tep_pkg::CFG_BITS-1:0]  frame_width,
  input  logic [tep_pkg::CFG_BITS-1:0]  frame_height,
  output logic signed [DW-1:0]          dx,
  output logic signed [DW-1:0]          dy,
  output logic [2*DW-1:0]               r
);
  import tep_pkg::*;

  logic signed [DW-1:0]   dx_a, dy_a, dx_b, dy_b;
  logic signed [2*DW-1:0] dx2, dy2;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a <= $signed(DW'({pixel_x, 1'b0})) - $signed(DW'(frame_width));
      dy_a <= $signed(DW'({pixel_y, 1'b0})) - $signed(DW'(frame_height));
      dx2  <= dx_a * dx_a;
      dy2  <= dy_a * dy_a;
      dx_b <= dx_a;
      dy_b <= dy_a;
      r    <= $unsigned(dx2) + $unsigned(dy2);
      dx   <= dx_b;
      dy   <= dy_b;
    end
  end

endmodule

>>> hw/rtl/tep_recip_sqrt.sv
module tep_recip_sqrt #(
  parameter int COORD_BITS = tep_pkg::COORD_BITS_DEF,
  localparam int RW = 2 * tep_pkg::diff_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [RW-1:0]                r,
  output logic [tep_pkg::TEX_BITS-1:0] tex_dist
);
  import tep_pkg::*;

  typedef struct packed {
    logic [RW-1:0]       rem;
    logic [DIV_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] v;
    logic [DIV_BITS:0]   res;
  } sq_t;

  function automatic div_t div_block(div_t cur, logic [RW-1:0] den, int first);
    div_t        nx;
    logic [RW:0] sh;
    nx = cur;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (first + j < DIV_BITS) begin
        // The numerator is a single one in its top bit.
        sh = {nx.rem, (first + j == 0)};
        if (sh >= (RW + 1)'(den)) begin
          sh = sh - (RW + 1)'(den);
          nx.quo[DIV_BITS-1-(first+j)] = 1'b1;
        end
        nx.rem = RW'(sh);
      end
    end
    return nx;
  endfunction

  function automatic sq_t sq_block(sq_t cur, int first);
    sq_t                nx;
    logic [DIV_BITS:0]  b;
    logic [DIV_BITS:0]  t;
    nx = cur;
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (first + j < SQ_ITERS) begin
        b = (DIV_BITS + 1)'(1) << (2 * (SQ_ITERS - 1 - (first + j)));
        t = nx.res + b;
        if ({1'b0, nx.v} >= t) begin
          nx.v   = DIV_BITS'({1'b0, nx.v} - t);
          nx.res = (nx.res >> 1) + b;
        end else begin
          nx.res = nx.res >> 1;
        end
      end
    end
    return nx;
  endfunction

  div_t          div_q   [DIV_STAGES];
  logic [RW-1:0] den_q   [DIV_STAGES];
  sq_t           sq_q    [SQ_STAGES];
  logic [LAT_RSQRT-1:0] zero_q;

  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0] <= div_block('0, r, 0);
      den_q[0] <= r;
      for (int s = 1; s < DIV_STAGES; s++) begin
        div_q[s] <= div_block(div_q[s-1], den_q[s-1], s * DIV_STEPS);
        den_q[s] <= den_q[s-1];
      end
      sq_q[0] <= sq_block('{v: div_q[DIV_STAGES-1].quo, res: '0}, 0);
      for (int s = 1; s < SQ_STAGES; s++) begin
        sq_q[s] <= sq_block(sq_q[s-1], s * SQ_STEPS);
      end
      zero_q <= {zero_q[LAT_RSQRT-2:0], (r == '0)};
    end
  end

  // A pixel on the centre has no defined inverse radius and reads as zero.
  assign tex_dist = zero_q[LAT_RSQRT-1] ? '0 : sq_q[SQ_STAGES-1].res[TEX_BITS-1:0];

endmodule

>>> hw/rtl/tep_cordic.sv
module tep_cordic #(
  parameter int COORD_BITS = tep_pkg::COORD_BITS_DEF,
  localparam int DW = tep_pkg::diff_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DW-1:0]         dx,
  input  logic signed [DW-1:0]         dy,
  output logic [tep_pkg::TEX_BITS-1:0] angle
);
  import tep_pkg::*;

  localparam int CW = DW + 18;

  typedef struct packed {
    logic signed [CW-1:0]       x;
    logic signed [CW-1:0]       y;
    logic signed [ACC_BITS-1:0] acc;
  } cor_t;

  function automatic cor_t cor_block(cor_t cur, int first);
    cor_t                 nx;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    nx = cur;
    for (int j = 0; j < COR_STEPS; j++) begin
      xs = nx.x >>> (first + j);
      ys = nx.y >>> (first + j);
      if (nx.y >= 0) begin
        nx.x   = nx.x + ys;
        nx.y   = nx.y - xs;
        nx.acc = nx.acc + ATAN_TAB[first+j];
      end else begin
        nx.x   = nx.x - ys;
        nx.y   = nx.y + xs;
        nx.acc = nx.acc - ATAN_TAB[first+j];
      end
    end
    return nx;
  endfunction

  cor_t                 pre;
  cor_t                 it_q [COR_STAGES+1];
  logic signed [CW-1:0] x0, y0;
  logic [COR_STAGES:0]  zero_q, behind_q;
  logic signed [ACC_BITS-1:0] acc_f;
  logic signed [ACC_BITS-1:0] quot;

  // Bring the vector into the right half plane before the iterations.
  always_comb begin
    x0 = CW'(dy) <<< 16;
    y0 = CW'(dx) <<< 16;
    pre = '{x: x0, y: y0, acc: '0};
    if (x0 < 0) begin
      if (y0 >= 0) begin
        pre = '{x: y0, y: -x0, acc: 18'sd32768};
      end else begin
        pre = '{x: -y0, y: x0, acc: -18'sd32768};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_q[0]  <= pre;
      zero_q   <= {zero_q[COR_STAGES-1:0], (dx == '0) && (dy == '0)};
      behind_q <= {behind_q[COR_STAGES-1:0], (dx == '0) && (dy < 0)};
      for (int s = 1; s <= COR_STAGES; s++) begin
        it_q[s] <= cor_block(it_q[s-1], (s - 1) * COR_STEPS);
      end
    end
  end

  // Division by 512 rounds towards zero.
  always_comb begin
    acc_f = it_q[COR_STAGES].acc;
    quot  = acc_f >>> 9;
    if (acc_f < 0 && acc_f[8:0] != '0) quot = quot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (behind_q[COR_STAGES]) begin
        angle <= ANGLE_HALF;
      end else if (zero_q[COR_STAGES]) begin
        angle <= '0;
      end else begin
        angle <= quot[TEX_BITS-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/tunnel_effect_pixel_generator.sv
// Tunnel-effect pixel generator: one pixel coordinate in, one palette index (0 to 36) out,
// for an xor-textured tunnel centred on the frame and scrolled by a frame counter that
// wraps at 200 and advances after each pixel marked last_of_frame. A new pixel can be
// taken in every clock cycle while out_stall is low, so the sustained rate is one pixel
// per cycle; the depth of the pipeline is set by the reciprocal path (three stages for
// the radius, seven for the 27-bit long division of 2^26 by the squared radius, four
// for the integer square root), with one entry and one output register around it.
// The arctangent CORDIC runs alongside in six stages and is delayed to match. The whole
// pipeline holds while a finished result waits on out_stall, so in_stall follows it in
// the same cycle. Frame width and height sit in an APB register file at byte addresses
// 0 and 4 and must only be written while the pipeline is empty.
module tunnel_effect_pixel_generator #(
  parameter int COORD_BITS = tep_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [COORD_BITS-1:0]          pixel_x,
  input  logic [COORD_BITS-1:0]          pixel_y,
  input  logic                           last_of_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tep_pkg::COLOR_BITS-1:0] color_index,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tep_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tep_pkg::*;

  localparam int DW       = diff_bits(COORD_BITS);
  // Stage holding the distance term, counted from the entry register.
  localparam int ALIGN    = LAT_RADIUS + LAT_RSQRT;
  localparam int PIPE_LEN = ALIGN + 2;
  localparam int ANG_DLY  = LAT_RSQRT - LAT_CORDIC;

  logic [CFG_BITS-1:0] frame_width, frame_height;
  logic [FC_BITS-1:0]  frame_count;
  logic                en, accept;
  logic [PIPE_LEN-1:0] vld;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic [TEX_BITS-1:0]   xs_d [ALIGN+1];
  logic [TEX_BITS-1:0]   ys_d [ALIGN+1];
  logic [TEX_BITS-1:0]   ang_d [ANG_DLY];

  logic signed [DW-1:0] dx, dy;
  logic [2*DW-1:0]      r;
  logic [TEX_BITS-1:0]  tex_dist, angle, tex_u, tex_v;

  // The pipeline moves as one unless a finished result is held at the output.
  assign en        = !(vld[PIPE_LEN-1] && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign out_valid = vld[PIPE_LEN-1];
  assign pready    = 1'b1;

  // Register file. Writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // The frame counter is sampled as each pixel enters, and steps after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
    end else if (accept && last_of_frame) begin
      frame_count <= (frame_count == FC_BITS'(FRAME_WRAP - 1)) ? '0 : frame_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], accept};
    end
  end

  // Entry register and the scroll offsets carried alongside the pixel.
  always_ff @(posedge clk) begin
    if (en) begin
      px_q    <= pixel_x;
      py_q    <= pixel_y;
      xs_d[0] <= X_SCROLL[frame_count];
      ys_d[0] <= Y_SCROLL[frame_count];
      for (int s = 1; s <= ALIGN; s++) begin
        xs_d[s] <= xs_d[s-1];
        ys_d[s] <= ys_d[s-1];
      end
      ang_d[0] <= angle;
      for (int s = 1; s < ANG_DLY; s++) ang_d[s] <= ang_d[s-1];
    end
  end

  tep_radius #(.COORD_BITS(COORD_BITS)) u_radius (
    .clk          (clk),
    .en           (en),
    .pixel_x      (px_q),
    .pixel_y      (py_q),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .dx           (dx),
    .dy           (dy),
    .r            (r)
  );

  tep_recip_sqrt #(.COORD_BITS(COORD_BITS)) u_recip_sqrt (
    .clk      (clk),
    .en       (en),
    .r        (r),
    .tex_dist (tex_dist)
  );

  tep_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
    .clk   (clk),
    .en    (en),
    .dx    (dx),
    .dy    (dy),
    .angle (angle)
  );

  // Texture coordinates wrap naturally in eight bits.
  assign tex_u = tex_dist + xs_d[ALIGN];
  assign tex_v = ang_d[ANG_DLY-1] + ys_d[ALIGN];

  always_ff @(posedge clk) begin
    if (en) begin
      color_index <= MOD37_TAB[tex_u ^ tex_v];
    end
  end

endmodule

>>> hw/rtl/tep_checker.sv
module tep_checker #(
  parameter int COORD_BITS = tep_pkg::COORD_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [COORD_BITS-1:0]          pixel_x,
  input logic [COORD_BITS-1:0]          pixel_y,
  input logic                           last_of_frame,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tep_pkg::COLOR_BITS-1:0] color_index,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [tep_pkg::PADDR_BITS-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);
  import tep_pkg::*;

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color_index))
    else $error("result changed while stalled");

  // Palette indices never exceed 36.
  a_color_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> color_index < COLOR_BITS'(37))
    else $error("palette index out of range");

  // The input side only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

endmodule

bind tunnel_effect_pixel_generator tep_checker #(.COORD_BITS(COORD_BITS)) u_tep_checker (.*);
